@@ rtl/iar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_pkg
// Shared codes and types for the indexed word array with insert and remove.
// ----------------------------------------------------------------------------
package iar_pkg;

	localparam int DEFAULT_DEPTH = 256;
	localparam int WORD_W        = 64;
	localparam int OP_W          = 3;
	localparam int INDEX_W       = 9;
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 9;
	// read-out tree reduces 2**TREE_FAN_LOG2 words per registered level
	localparam int TREE_FAN_LOG2 = 4;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_REMOVE = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      rd;
	} cell_ctl_t;

endpackage

@@ rtl/iar_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_cell
// One storage cell of the word chain: holds one word, shifts to or from its
// neighbors, and offers its word for read-out when addressed.
// ----------------------------------------------------------------------------
module iar_cell #(
	parameter int IW  = 8,
	parameter int POS = 0
) (
	input  logic                       clk,
	input  iar_pkg::cell_ctl_t         ctl,
	input  logic [IW-1:0]              idx,
	input  logic [iar_pkg::WORD_W-1:0] value,
	input  logic [iar_pkg::WORD_W-1:0] left,
	input  logic [iar_pkg::WORD_W-1:0] right,
	output logic [iar_pkg::WORD_W-1:0] word,
	output logic [iar_pkg::WORD_W-1:0] rd_data
);
	import iar_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic              hit;
	logic              above;

	assign hit   = (idx == IW'(POS));
	assign above = (IW'(POS) > idx);

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_WRITE: begin
				if (hit) word_q <= value;
			end
			CMD_INSERT: begin
				if (hit) word_q <= value;
				else if (above) word_q <= left;
			end
			CMD_REMOVE: begin
				if (hit || above) word_q <= right;
			end
			default: begin
			end
		endcase
	end

	assign word    = word_q;
	// unaddressed cells give zero so the read-out tree can OR them together
	assign rd_data = (ctl.rd && hit) ? word_q : '0;

endmodule

@@ rtl/iar_or_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iar_or_tree
// Registered OR-reduction tree that collects the one addressed word from
// all cells, one level of fan-in per clock.
// ----------------------------------------------------------------------------
module iar_or_tree #(
	parameter int N = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [iar_pkg::WORD_W-1:0] in_data [N],
	output logic                       out_valid,
	output logic [iar_pkg::WORD_W-1:0] out_data
);
	import iar_pkg::*;

	localparam int FL   = TREE_FAN_LOG2;
	localparam int FAN  = 1 << FL;
	localparam int LVLS = ($clog2(N) + FL - 1) / FL;

	logic [WORD_W-1:0] node_q [LVLS][N];
	logic [LVLS-1:0]   vld_q;

	for (genvar l = 0; l < LVLS; l++) begin : g_lvl
		localparam int CNT  = (N + (1 << (FL * (l + 1))) - 1) >> (FL * (l + 1));
		localparam int PCNT = (N + (1 << (FL * l)) - 1) >> (FL * l);
		for (genvar j = 0; j < N; j++) begin : g_node
			if (j < CNT) begin : g_used
				logic [WORD_W-1:0] kid [FAN];
				logic [WORD_W-1:0] acc;
				for (genvar k = 0; k < FAN; k++) begin : g_kid
					if (j * FAN + k < PCNT) begin : g_src
						if (l == 0) begin : g_leaf
							assign kid[k] = in_data[j * FAN + k];
						end else begin : g_inner
							assign kid[k] = node_q[l-1][j * FAN + k];
						end
					end else begin : g_pad
						assign kid[k] = '0;
					end
				end
				always_comb begin
					acc = '0;
					for (int k = 0; k < FAN; k++) acc = acc | kid[k];
				end
				always_ff @(posedge clk) begin
					node_q[l][j] <= acc;
				end
			end else begin : g_unused
				always_ff @(posedge clk) begin
					node_q[l][j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= LVLS'({vld_q, in_valid});
		end
	end

	assign out_valid = vld_q[LVLS-1];
	assign out_data  = node_q[LVLS-1][0];

endmodule

@@ rtl/indexed_array_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_remove
// Ordered list of up to DEPTH 64-bit words kept in a chain of cells: push,
// pop, insert, remove, read and overwrite by signed index.
// done rises when the result leaves the read-out OR tree, which is LVLS
// registered levels deep (ceil(log16(DEPTH)); 2 for DEPTH 256). busy stays
// high from acceptance until done, so a new request is taken only once the
// last has finished; shifts for insert and remove happen in the cell chain.
// Reset clears the count and control state; cell contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove #(
	parameter int DEPTH = iar_pkg::DEFAULT_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [iar_pkg::OP_W-1:0]        op,
	input  logic signed [iar_pkg::INDEX_W-1:0] index,
	input  logic [iar_pkg::WORD_W-1:0]      value,
	output logic                            done,
	output logic [iar_pkg::STATUS_W-1:0]    status,
	output logic [iar_pkg::WORD_W-1:0]      data_out,
	output logic [iar_pkg::COUNT_OUT_W-1:0] count_out
);
	import iar_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	cell_ctl_t           ctl_q;
	logic [IW-1:0]       idx_q;
	logic [WORD_W-1:0]   value_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept;
	logic signed [RW-1:0] idx_sx;
	logic signed [RW-1:0] adj;
	logic [RW-1:0]       cnt_x;
	logic                in_rd;
	logic                in_ins;
	logic                full;
	cell_ctl_t           nxt_ctl;
	logic [IW-1:0]       nxt_idx;
	logic [STATUS_W-1:0] nxt_status;
	logic [CW-1:0]       nxt_count;

	cell_ctl_t           cell_ctl;
	logic [WORD_W-1:0]   word    [DEPTH];
	logic [WORD_W-1:0]   rd_data [DEPTH];
	logic                tree_valid;
	logic [WORD_W-1:0]   tree_data;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q >= CW'(DEPTH));

	// negative index counts back from the current count, once
	always_comb begin
		idx_sx = {{(RW - INDEX_W){index[INDEX_W-1]}}, index};
		cnt_x  = {{(RW - CW){1'b0}}, count_q};
		adj    = index[INDEX_W-1] ? (idx_sx + $signed(cnt_x)) : idx_sx;
		in_rd  = !adj[RW-1] && (RW'(adj) < cnt_x);
		in_ins = !adj[RW-1] && (RW'(adj) <= cnt_x);
	end

	always_comb begin
		nxt_ctl    = '{cmd: CMD_NONE, rd: 1'b0};
		nxt_idx    = adj[IW-1:0];
		nxt_status = ST_OK;
		nxt_count  = count_q;
		case (op)
			OP_PUSH: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					nxt_ctl.cmd = CMD_WRITE;
					nxt_idx     = count_q[IW-1:0];
					nxt_count   = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_ctl.rd = 1'b1;
					nxt_idx    = IW'(count_q - 1'b1);
					nxt_count  = count_q - 1'b1;
				end
			end
			OP_INSERT: begin
				if (!in_ins) begin
					nxt_status = ST_RANGE;
				end else if (full) begin
					nxt_status = ST_FULL;
				end else begin
					nxt_ctl.cmd = CMD_INSERT;
					nxt_count   = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!in_rd) begin
					nxt_status = ST_RANGE;
				end else begin
					nxt_ctl.cmd = CMD_REMOVE;
					nxt_ctl.rd  = 1'b1;
					nxt_count   = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (!in_rd) nxt_status = ST_RANGE;
				else nxt_ctl.rd = 1'b1;
			end
			OP_WRITE: begin
				if (!in_rd) nxt_status = ST_RANGE;
				else nxt_ctl.cmd = CMD_WRITE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ctl_q    <= '{cmd: CMD_NONE, rd: 1'b0};
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_EXEC;
						count_q  <= nxt_count;
						ctl_q    <= nxt_ctl;
						status_q <= nxt_status;
					end
				end
				S_EXEC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (tree_valid) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= nxt_idx;
			value_q <= value;
		end
	end

	// cells act only in the execute cycle; the tree samples the pre-shift word
	assign cell_ctl = (state_q == S_EXEC) ? ctl_q : cell_ctl_t'{cmd: CMD_NONE, rd: 1'b0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = word[i+1];
		end
		iar_cell #(
			.IW  (IW),
			.POS (i)
		) u_cell (
			.clk     (clk),
			.ctl     (cell_ctl),
			.idx     (idx_q),
			.value   (value_q),
			.left    (left),
			.right   (right),
			.word    (word[i]),
			.rd_data (rd_data[i])
		);
	end

	iar_or_tree #(
		.N (DEPTH)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (state_q == S_EXEC),
		.in_data   (rd_data),
		.out_valid (tree_valid),
		.out_data  (tree_data)
	);

	assign done      = tree_valid;
	assign status    = status_q;
	assign data_out  = tree_data;
	assign count_out = COUNT_OUT_W'(count_q);

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_WAIT))
		else $error("result strobe outside wait state");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execute");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q != ST_OK)) |-> (data_out == '0))
		else $error("failed request returned nonzero data");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed word list. A shadow copy of the list
// predicts status, word and count for every accepted request; a monitor
// compares each done strobe against the oldest prediction. Directed requests
// cover the empty list and the index corner cases, then random traffic
// grows the list to full, works at full, drains it and mixes again.
// ----------------------------------------------------------------------------
module tb;

	import iar_pkg::*;

	localparam int DEPTH          = 256;
	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_DRAIN      = 10;
	localparam int MAX_REPORTS    = 50;

	// op codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

	typedef struct {
		logic [STATUS_W-1:0]    status;
		logic [WORD_W-1:0]      word;
		logic [COUNT_OUT_W-1:0] count;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          op;
	logic signed [INDEX_W-1:0] index;
	logic [WORD_W-1:0]        value;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [WORD_W-1:0]        data_out;
	logic [COUNT_OUT_W-1:0]   count_out;

	// shadow copy of the list
	logic [WORD_W-1:0] shadow_words [DEPTH];
	int                shadow_count;

	list_result_t pending_results [$];
	int           mismatch_count;
	int           idle_cycles;
	int           burst_left;

	indexed_array_insert_remove #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.index    (index),
		.value    (value),
		.done     (done),
		.status   (status),
		.data_out (data_out),
		.count_out(count_out)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// signed index against current count; -1 when out of range
	function automatic int resolve_position(input logic signed [INDEX_W-1:0] raw,
			input bit allow_end);
		int pos;
		pos = raw;
		if (pos < 0)
			pos = pos + shadow_count;
		if (pos < 0)
			return -1;
		if (pos > shadow_count)
			return -1;
		if (pos == shadow_count && !allow_end)
			return -1;
		return pos;
	endfunction

	function automatic list_result_t apply_request(input logic [OP_W-1:0] req_op,
			input logic signed [INDEX_W-1:0] req_index, input logic [WORD_W-1:0] req_value);
		list_result_t res;
		int pos;
		int i;
		res.status = ST_OK;
		res.word   = '0;
		case (req_op)
			OP_PUSH: begin
				if (shadow_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_count] = req_value;
					shadow_count++;
				end
			end
			OP_POP: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					shadow_count--;
					res.word = shadow_words[shadow_count];
				end
			end
			OP_INSERT: begin
				pos = resolve_position(req_index, 1'b1);
				if (pos < 0) begin
					res.status = ST_RANGE;
				end else if (shadow_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = req_value;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				pos = resolve_position(req_index, 1'b0);
				if (pos < 0) begin
					res.status = ST_RANGE;
				end else begin
					res.word = shadow_words[pos];
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_count--;
				end
			end
			OP_READ: begin
				pos = resolve_position(req_index, 1'b0);
				if (pos < 0)
					res.status = ST_RANGE;
				else
					res.word = shadow_words[pos];
			end
			OP_WRITE: begin
				pos = resolve_position(req_index, 1'b0);
				if (pos < 0)
					res.status = ST_RANGE;
				else
					shadow_words[pos] = req_value;
			end
			default: begin
			end
		endcase
		res.count = shadow_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
	endtask

	// one request; requests go out in bursts with idle gaps between
	task automatic send_request(input logic [OP_W-1:0] req_op,
			input logic signed [INDEX_W-1:0] req_index, input logic [WORD_W-1:0] req_value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		start <= 1'b1;
		op    <= req_op;
		index <= req_index;
		value <= req_value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_request(req_op, req_index, req_value));
		burst_left--;
	endtask

	task automatic send_random(input int w_push, input int w_pop, input int w_ins,
			input int w_rem, input int w_rd, input int w_wr, input int w_spare);
		logic [OP_W-1:0]           rnd_op;
		logic signed [INDEX_W-1:0] rnd_index;
		logic [WORD_W-1:0]         rnd_value;
		int pick;
		int span;
		int pos;
		pick = $urandom_range(0, w_push + w_pop + w_ins + w_rem + w_rd + w_wr + w_spare - 1);
		if (pick < w_push)
			rnd_op = OP_PUSH;
		else if (pick < w_push + w_pop)
			rnd_op = OP_POP;
		else if (pick < w_push + w_pop + w_ins)
			rnd_op = OP_INSERT;
		else if (pick < w_push + w_pop + w_ins + w_rem)
			rnd_op = OP_REMOVE;
		else if (pick < w_push + w_pop + w_ins + w_rem + w_rd)
			rnd_op = OP_READ;
		else if (pick < w_push + w_pop + w_ins + w_rem + w_rd + w_wr)
			rnd_op = OP_WRITE;
		else
			rnd_op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;

		// mostly in-range positions, given either way round; the rest anything
		span = (rnd_op == OP_INSERT) ? shadow_count + 1 : shadow_count;
		if (span > 0 && $urandom_range(0, 9) < 7) begin
			pos = $urandom_range(0, span - 1);
			if (pos < shadow_count && $urandom_range(0, 1))
				rnd_index = INDEX_W'(pos - shadow_count);
			else
				rnd_index = INDEX_W'(pos);
		end else begin
			rnd_index = INDEX_W'($urandom);
		end

		case ($urandom_range(0, 9))
			0:       rnd_value = '0;
			1:       rnd_value = ALL_ONES;
			default: rnd_value = {$urandom, $urandom};
		endcase
		send_request(rnd_op, rnd_index, rnd_value);
	endtask

	// hold off until every outstanding request has answered
	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_request(OP_POP, 9'sd0, '0);
		send_request(OP_REMOVE, 9'sd0, '0);
		send_request(OP_READ, 9'sd0, '0);
		send_request(OP_WRITE, -9'sd1, ALL_ONES);
		send_request(OP_INSERT, 9'sd1, ALL_ONES);   // beyond count
		send_request(OP_INSERT, -9'sd1, ALL_ONES);  // still negative
		send_request(OP_SPARE6, -9'sd256, ALL_ONES);
		send_request(OP_SPARE7, 9'sd255, ALL_ONES);
	endtask

	task automatic test_basic_ops();
		send_request(OP_PUSH, 9'sd0, '0);
		send_request(OP_PUSH, 9'sd0, ALL_ONES);
		send_request(OP_INSERT, 9'sd2, 64'hA5A5_5A5A_0F0F_F0F0);  // at count: append
		send_request(OP_INSERT, 9'sd0, 64'h5A5A_A5A5_F0F0_0F0F);
		send_request(OP_INSERT, -9'sd1, 64'h0123_4567_89AB_CDEF);
		send_request(OP_READ, -9'sd256, '0);
		send_request(OP_READ, 9'sd255, '0);
		send_request(OP_READ, -9'sd1, '0);
		send_request(OP_READ, 9'sd0, '0);
		send_request(OP_WRITE, 9'sd1, 64'hFEDC_BA98_7654_3210);
		send_request(OP_READ, 9'sd1, '0);
		send_request(OP_REMOVE, -9'sd2, '0);
		send_request(OP_REMOVE, 9'sd0, '0);
		send_request(OP_POP, 9'sd0, '0);
		send_request(OP_SPARE7, -9'sd1, ALL_ONES);
	endtask

	task automatic test_random_mix(input int n);
		repeat (n)
			send_random(22, 18, 18, 16, 12, 10, 4);
	endtask

	task automatic test_fill_to_full();
		while (shadow_count < DEPTH)
			send_random(45, 5, 35, 5, 5, 5, 0);
	endtask

	task automatic test_full_list(input int n);
		repeat (n)
			send_random(30, 5, 30, 5, 15, 15, 0);
	endtask

	task automatic test_drain_to_empty();
		while (shadow_count > 0)
			send_random(5, 40, 5, 35, 8, 7, 0);
		send_random(0, 1, 0, 1, 0, 0, 0);
	endtask

	// result monitor
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {62'd0, status}, '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", {62'd0, status}, {62'd0, want.status});
				if (data_out !== want.word)
					report_mismatch("data_out", data_out, want.word);
				if (count_out !== want.count)
					report_mismatch("count_out", {55'd0, count_out}, {55'd0, want.count});
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		op             = OP_PUSH;
		index          = '0;
		value          = '0;
		shadow_count   = 0;
		mismatch_count = 0;
		idle_cycles    = 0;
		burst_left     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_basic_ops();
		wait_all_results();
		test_random_mix(120);
		test_fill_to_full();
		wait_all_results();
		test_full_list(30);
		test_drain_to_empty();
		wait_all_results();
		test_random_mix(100);

		wait_all_results();
		repeat (END_DRAIN) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/iar_pkg.sv
rtl/iar_cell.sv
rtl/iar_or_tree.sv
rtl/indexed_array_insert_remove.sv
tb/tb.sv
